/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define SET_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset
`define SET_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SET_ASSERT(label, clk, rst, prop, msg)
`define SET_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* rtl/core/set_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Shared widths, register indexes, reset values and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package set_pkg;

   // Pixel and geometry
   localparam int PIXEL_BITS      = 8;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_MAX_HEIGHT  = 4096;
   localparam int MIN_IMAGE_WIDTH = 2;
   localparam int MIN_IMAGE_HEIGHT = 1;
   localparam int ROW_W           = 13;
   localparam logic [ROW_W-1:0] ROW_COUNTER_MAX = 13'd8191;

   // Configuration registers
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int CFG_THRESH_BITS = 11;
   localparam int CSR_DATA_W      = 13;
   localparam int CSR_INDEX_W     = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_EDGE_THRESHOLD = 2'd2;
   localparam logic [CFG_WIDTH_BITS-1:0]  RST_IMAGE_WIDTH    = 11'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT   = 13'd480;
   localparam logic [CFG_THRESH_BITS-1:0] RST_EDGE_THRESHOLD = 11'd60;

   // Gradient arithmetic
   localparam int MAG_W = 10;   // |gx|, |gy| and one-sided kernel sums, up to 1020
   localparam int SQ_W  = 20;   // squared magnitude of one axis
   localparam int LIM_W = 24;   // (threshold + 1)^2 and gx^2 + gy^2

   // Result buffer
   localparam int OUT_FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
   localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // 3x3 window, row-major, top row and left column first
   typedef logic [8:0][PIXEL_BITS-1:0] set_win_type;

   typedef struct packed {
      logic                  action;
      logic [PIXEL_BITS-1:0] pixel;
   } set_req_type;

   typedef struct packed {
      logic edge_res;
      logic last_of_frame;
   } set_rsp_type;

   // Per-item control handed from the counter stage to the line memory stage
   typedef struct packed {
      logic [PIXEL_BITS-1:0] cur;
      logic                  emit;
      logic                  top;
      logic                  bottom;
      logic                  left;
      logic                  right;
      logic                  last;
   } set_item_type;

   // Issue status of the current input transaction
   typedef struct packed {
      logic rd_en;
      logic emit;
   } set_issue_type;

endpackage

`default_nettype wire

/* rtl/core/sobel_edge_threshold_unit.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold unit
// Streaming 3x3 Sobel edge detector with a magnitude threshold.
//   req_*: one transaction per grey pixel in raster order (action = 0), then
//     image_width + 1 flush transactions (action = 1) after the last pixel.
//     Flush transactions outside a frame are taken and dropped.
//   rsp_*: one edge flag per image position, lagging its pixel by
//     image_width + 1 input transactions; last_of_frame marks the final one.
//   csr_*: image_width, image_height, edge_threshold; write only while idle.
//   Throughput: one input transaction per clock while req_ready is high.
//   The line memory does one read and one write back per cycle, which sets
//   that rate. A result passes the item register, the window register, the
//   magnitude and square stages and the result buffer on its way to rsp_*.
//   Reset: registers return to 640 x 480, threshold 60; counters and window
//   clear at once. The line memory needs no clearing pass.
//   Stall: an 8-entry result buffer absorbs rsp_ready low; req_ready drops
//   when buffered plus in-flight results reach 8.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sobel_edge_threshold_unit #(
   parameter int MAX_WIDTH  = set_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = set_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire set_pkg::set_req_type              req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output set_pkg::set_rsp_type                   rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [set_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [set_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = set_pkg::FIFO_CNT_W;
   localparam int OCC_W = CNT_W + 1;

   logic [set_pkg::CFG_WIDTH_BITS-1:0]  image_width_ff;
   logic [set_pkg::CFG_HEIGHT_BITS-1:0] image_height_ff;
   logic [set_pkg::CFG_THRESH_BITS-1:0] edge_threshold_ff;

   logic                  take;
   set_pkg::set_issue_type issue;
   logic [COL_W-1:0]      rd_col;
   logic                  item_valid;
   set_pkg::set_item_type item;
   logic [COL_W-1:0]      item_col;
   logic                  win_valid;
   set_pkg::set_win_type  win;
   logic                  win_last;
   logic                  push;
   set_pkg::set_rsp_type  push_data;
   logic [CNT_W-1:0]      fifo_count;
   logic [CNT_W-1:0]      pending_ff, pending_in;
   logic [OCC_W-1:0]      occupancy;
   logic                  issue_emit;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= set_pkg::RST_IMAGE_WIDTH;
         image_height_ff   <= set_pkg::RST_IMAGE_HEIGHT;
         edge_threshold_ff <= set_pkg::RST_EDGE_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            set_pkg::CSR_IDX_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[set_pkg::CFG_WIDTH_BITS-1:0];
            end
            set_pkg::CSR_IDX_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[set_pkg::CFG_HEIGHT_BITS-1:0];
            end
            set_pkg::CSR_IDX_EDGE_THRESHOLD: begin
               edge_threshold_ff <= csr_wdata[set_pkg::CFG_THRESH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Admission: buffered results plus results still in the pipeline
   assign occupancy  = OCC_W'(fifo_count) + OCC_W'(pending_ff);
   assign req_ready  = occupancy < OCC_W'(set_pkg::OUT_FIFO_DEPTH);
   assign take       = req_valid && req_ready;
   assign issue_emit = issue.rd_en && issue.emit;

   always_comb begin
      pending_in = pending_ff;
      if (issue_emit && !push) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (push && !issue_emit) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   set_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .req_payload  (req_payload),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .issue        (issue),
      .rd_col       (rd_col),
      .item_valid   (item_valid),
      .item         (item),
      .item_col     (item_col)
   );

   set_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (issue.rd_en),
      .rd_col     (rd_col),
      .item_valid (item_valid),
      .item       (item),
      .item_col   (item_col),
      .win_valid  (win_valid),
      .win        (win),
      .win_last   (win_last)
   );

   set_grad u_grad (
      .clock          (clock),
      .reset          (reset),
      .win_valid      (win_valid),
      .win            (win),
      .win_last       (win_last),
      .edge_threshold (edge_threshold_ff),
      .push           (push),
      .push_data      (push_data)
   );

   set_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .count       (fifo_count)
   );

   `SET_ASSERT_NEVER(a_occupancy_bound, clock, reset, occupancy > OCC_W'(set_pkg::OUT_FIFO_DEPTH), "in-flight results exceed buffer space")

endmodule

`default_nettype wire

/* rtl/core/set_ctrl.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold position control
// Tracks input and result positions, decides emission, borders and frame end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module set_ctrl #(
   parameter int MAX_WIDTH  = set_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = set_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  take,
   input  wire set_pkg::set_req_type                  req_payload,
   input  wire logic [set_pkg::CFG_WIDTH_BITS-1:0]    image_width,
   input  wire logic [set_pkg::CFG_HEIGHT_BITS-1:0]   image_height,
   output set_pkg::set_issue_type                     issue,
   output logic [$clog2(MAX_WIDTH)-1:0]               rd_col,
   output logic                                       item_valid,
   output set_pkg::set_item_type                      item,
   output logic [$clog2(MAX_WIDTH)-1:0]               item_col
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = COL_W + 1;
   localparam int CMPW_W = (WCNT_W > set_pkg::CFG_WIDTH_BITS) ? WCNT_W
                                                               : set_pkg::CFG_WIDTH_BITS;
   localparam int HLIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int CMPH_W = (HLIM_W > set_pkg::CFG_HEIGHT_BITS) ? HLIM_W
                                                                : set_pkg::CFG_HEIGHT_BITS;
   localparam int ROW_W  = set_pkg::ROW_W;
   localparam int ROWX_W = ROW_W + 1;

   logic [CMPW_W-1:0] width_ext;
   logic [CMPW_W-1:0] width_clamp;
   logic [WCNT_W-1:0] w_eff;
   logic [CMPH_W-1:0] height_ext;
   logic [CMPH_W-1:0] height_clamp;
   logic [ROW_W-1:0]  h_eff;

   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic              item_valid_ff, item_valid_in;
   set_pkg::set_item_type item_ff, item_in;
   logic [COL_W-1:0]  item_col_ff;

   logic [WCNT_W-1:0] in_col_inc;
   logic [WCNT_W-1:0] out_col_inc;
   logic [ROWX_W-1:0] out_row_inc;
   logic              in_wrap;
   logic              out_right;
   logic              out_bottom;
   logic              in_below;
   logic              emit;
   logic              skip;
   logic              step;
   logic              last;

   // Clamp the geometry registers to the supported range
   always_comb begin
      width_ext  = CMPW_W'(image_width);
      height_ext = CMPH_W'(image_height);
      if (width_ext < CMPW_W'(set_pkg::MIN_IMAGE_WIDTH)) begin
         width_clamp = CMPW_W'(set_pkg::MIN_IMAGE_WIDTH);
      end else if (width_ext > CMPW_W'(MAX_WIDTH)) begin
         width_clamp = CMPW_W'(MAX_WIDTH);
      end else begin
         width_clamp = width_ext;
      end
      if (height_ext < CMPH_W'(set_pkg::MIN_IMAGE_HEIGHT)) begin
         height_clamp = CMPH_W'(set_pkg::MIN_IMAGE_HEIGHT);
      end else if (height_ext > CMPH_W'(MAX_HEIGHT)) begin
         height_clamp = CMPH_W'(MAX_HEIGHT);
      end else begin
         height_clamp = height_ext;
      end
      w_eff = WCNT_W'(width_clamp);
      h_eff = ROW_W'(height_clamp);
   end

   // Position decode for the current transaction
   always_comb begin
      in_col_inc  = WCNT_W'(in_col_ff) + WCNT_W'(1);
      out_col_inc = WCNT_W'(out_col_ff) + WCNT_W'(1);
      out_row_inc = ROWX_W'(out_row_ff) + ROWX_W'(1);
      in_wrap     = in_col_inc >= w_eff;
      out_right   = out_col_inc >= w_eff;
      out_bottom  = out_row_inc >= ROWX_W'(h_eff);
      in_below    = in_row_ff >= h_eff;
      emit        = (in_row_ff >= ROW_W'(2)) ||
                    ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      // flush with no frame under way is dropped
      skip        = req_payload.action && (in_row_ff == '0) && (in_col_ff == '0);
      step        = take && !skip;
      last        = emit && out_bottom && out_right;
   end

   // Next counter values and item descriptor
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (step) begin
         if (in_wrap) begin
            in_col_in = '0;
            if (in_row_ff != set_pkg::ROW_COUNTER_MAX) begin
               in_row_in = in_row_ff + ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_right) begin
               out_col_in = '0;
               if (out_row_ff != set_pkg::ROW_COUNTER_MAX) begin
                  out_row_in = out_row_ff + ROW_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
      item_valid_in  = step;
      item_in.cur    = (req_payload.action || in_below) ? '0 : req_payload.pixel;
      item_in.emit   = emit;
      item_in.top    = (out_row_ff == '0);
      item_in.bottom = out_bottom;
      item_in.left   = (out_col_ff == '0);
      item_in.right  = out_right;
      item_in.last   = last;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         item_valid_ff <= item_valid_in;
      end
   end

   // Item payload toward the line memory stage
   always_ff @(posedge clock) begin
      if (step) begin
         item_ff     <= item_in;
         item_col_ff <= in_col_ff;
      end
   end

   assign issue.rd_en = step;
   assign issue.emit  = emit;
   assign rd_col      = in_col_ff;
   assign item_valid  = item_valid_ff;
   assign item        = item_ff;
   assign item_col    = item_col_ff;

   `SET_ASSERT(a_skip_no_item, clock, reset, (take && skip) |=> !item_valid_ff, "dropped flush issued an item")
   `SET_ASSERT(a_frame_restart, clock, reset, (step && last) |=> ((in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0)), "counters not cleared at frame end")

endmodule

`default_nettype wire

/* rtl/core/set_line_mem.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold line memory and window
// Two-row line memory with read-modify-write, forwarding and the 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module set_line_mem #(
   parameter int MAX_WIDTH = set_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_col,
   input  wire logic                        item_valid,
   input  wire set_pkg::set_item_type       item,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] item_col,
   output logic                             win_valid,
   output set_pkg::set_win_type             win,
   output logic                             win_last
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int PIX_W  = set_pkg::PIXEL_BITS;
   localparam int WORD_W = 2 * PIX_W;

   // Each word holds {row two above, row above} for one column
   logic [WORD_W-1:0] lbuf_mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] last_wr_ff;
   logic              fwd_ff, fwd_in;

   logic [WORD_W-1:0] cur_word;
   logic [WORD_W-1:0] wr_word;
   set_pkg::pix_type  far_pix;
   set_pkg::pix_type  near_pix;

   set_pkg::set_win_type win_ff;
   set_pkg::set_win_type shifted;
   set_pkg::set_win_type masked;
   set_pkg::set_win_type win_out_ff;
   logic                 win_valid_ff;
   logic                 win_last_ff;

   // Back-to-back transactions on one column: the write of the older one is
   // still in flight when the younger one reads
   assign fwd_in = rd_en && item_valid && (rd_col == item_col);

   // Resolve the read word and build the write-back word
   always_comb begin
      cur_word = fwd_ff ? last_wr_ff : rd_word_ff;
      far_pix  = cur_word[WORD_W-1:PIX_W];
      near_pix = cur_word[PIX_W-1:0];
      wr_word  = {near_pix, item.cur};
   end

   // Line memory: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= lbuf_mem[rd_col];
      end
      if (item_valid) begin
         lbuf_mem[item_col] <= wr_word;
         last_wr_ff         <= wr_word;
      end
   end

   // Window shift and border masking
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         shifted[r*3]     = win_ff[r*3 + 1];
         shifted[r*3 + 1] = win_ff[r*3 + 2];
      end
      shifted[2] = far_pix;
      shifted[5] = near_pix;
      shifted[8] = item.cur;

      masked = shifted;
      if (item.top) begin
         masked[0] = '0;
         masked[1] = '0;
         masked[2] = '0;
      end
      if (item.bottom) begin
         masked[6] = '0;
         masked[7] = '0;
         masked[8] = '0;
      end
      if (item.left) begin
         masked[0] = '0;
         masked[3] = '0;
         masked[6] = '0;
      end
      if (item.right) begin
         masked[2] = '0;
         masked[5] = '0;
         masked[8] = '0;
      end
   end

   // Window state and forwarding flag
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fwd_ff       <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         win_valid_ff <= item_valid && item.emit;
         if (item_valid) begin
            win_ff <= item.last ? '0 : shifted;
         end
      end
   end

   // Masked window toward the gradient stage
   always_ff @(posedge clock) begin
      if (item_valid) begin
         win_out_ff  <= masked;
         win_last_ff <= item.last;
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_out_ff;
   assign win_last  = win_last_ff;

   `SET_ASSERT(a_win_clear, clock, reset, (item_valid && item.last) |=> (win_ff == '0), "window not cleared at frame end")

endmodule

`default_nettype wire

/* rtl/core/set_grad.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold gradient
// Kernel sums, squared magnitude and threshold compare over stages a and b.
// ----------------------------------------------------------------------------
`default_nettype none

module set_grad (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 win_valid,
   input  wire set_pkg::set_win_type                 win,
   input  wire logic                                 win_last,
   input  wire logic [set_pkg::CFG_THRESH_BITS-1:0]  edge_threshold,
   output logic                                      push,
   output set_pkg::set_rsp_type                      push_data
);

   localparam int MAG_W = set_pkg::MAG_W;
   localparam int SQ_W  = set_pkg::SQ_W;
   localparam int LIM_W = set_pkg::LIM_W;
   localparam int THP_W = set_pkg::CFG_THRESH_BITS + 1;

   logic [MAG_W-1:0] px, nx, py, ny;
   logic [MAG_W-1:0] ax_in, ay_in;
   logic [MAG_W-1:0] ax_ff, ay_ff;
   logic             a_valid_ff, a_last_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic             b_valid_ff, b_last_ff;
   logic [THP_W-1:0] thr_p1;
   logic [LIM_W-1:0] lim_ff;
   logic [LIM_W-1:0] mag_sq;
   logic             is_edge;

   // Kernel halves: positive and negative taps summed apart
   always_comb begin
      px = MAG_W'(win[2]) + MAG_W'({win[5], 1'b0}) + MAG_W'(win[8]);
      nx = MAG_W'(win[0]) + MAG_W'({win[3], 1'b0}) + MAG_W'(win[6]);
      py = MAG_W'(win[6]) + MAG_W'({win[7], 1'b0}) + MAG_W'(win[8]);
      ny = MAG_W'(win[0]) + MAG_W'({win[1], 1'b0}) + MAG_W'(win[2]);
      ax_in = (px >= nx) ? (px - nx) : (nx - px);
      ay_in = (py >= ny) ? (py - ny) : (ny - py);
   end

   // (threshold+1)^2 limit; unchecked: user keeps it static with items in flight
   assign thr_p1 = THP_W'(edge_threshold) + THP_W'(1);

   always_ff @(posedge clock) begin
      lim_ff <= LIM_W'(thr_p1) * LIM_W'(thr_p1);
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= win_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Magnitudes, then squares
   always_ff @(posedge clock) begin
      if (win_valid) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         a_last_ff <= win_last;
      end
      if (a_valid_ff) begin
         sqx_ff    <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         sqy_ff    <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         b_last_ff <= a_last_ff;
      end
   end

   // Compare against the limit
   always_comb begin
      mag_sq                  = LIM_W'(sqx_ff) + LIM_W'(sqy_ff);
      is_edge                 = mag_sq >= lim_ff;
      push                    = b_valid_ff;
      push_data.edge_res      = is_edge;
      push_data.last_of_frame = b_last_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/set_out_fifo.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold result buffer
// Small register FIFO between the gradient pipeline and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module set_out_fifo (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire set_pkg::set_rsp_type              push_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output set_pkg::set_rsp_type                   rsp_payload,
   output logic [set_pkg::FIFO_CNT_W-1:0]         count
);

   localparam int DEPTH = set_pkg::OUT_FIFO_DEPTH;
   localparam int PTR_W = set_pkg::FIFO_PTR_W;
   localparam int CNT_W = set_pkg::FIFO_CNT_W;

   set_pkg::set_rsp_type fifo_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic             full;

   assign pop  = rsp_ready && (count_ff != '0);
   assign full = (count_ff == CNT_W'(DEPTH));

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = fifo_mem[rd_ptr_ff];
   assign count       = count_ff;

   `SET_ASSERT_NEVER(a_no_overflow, clock, reset, push && full && !pop, "result buffer overflow")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge threshold unit testbench
// Streams raster frames of grey pixels and flush transactions into the unit.
// A cycle-free predictor of the line memories, the 3x3 window and the raster
// counters works out every edge flag, and a monitor compares each result
// transaction field by field. Frame geometry and threshold are rewritten
// between frames and, where safe, in the middle of one.
// ----------------------------------------------------------------------------

module tb;

   localparam logic ACT_PIXEL     = 1'b0;
   localparam logic ACT_FLUSH     = 1'b1;
   localparam int   SETTLE_CYCLES = 12;
   localparam int   LONG_HOLD     = 300;
   localparam int   RANDOM_ITEMS  = 360;
   localparam int   MAX_WAIT      = 13;
   localparam int   TIMEOUT_NS    = 400_000;

   typedef enum int {STYLE_NOISE, STYLE_BINARY, STYLE_SMOOTH} img_style_type;

   // Clock and DUT connections
   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   set_pkg::set_req_type            req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   set_pkg::set_rsp_type            rsp_payload;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [set_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [set_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   always #1 clock = ~clock;

   sobel_edge_threshold_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Predictor state: registers, line memories, window, raster counters
   logic [set_pkg::CFG_WIDTH_BITS-1:0]  cfg_width  = set_pkg::RST_IMAGE_WIDTH;
   logic [set_pkg::CFG_HEIGHT_BITS-1:0] cfg_height = set_pkg::RST_IMAGE_HEIGHT;
   logic [set_pkg::CFG_THRESH_BITS-1:0] cfg_thresh = set_pkg::RST_EDGE_THRESHOLD;
   set_pkg::pix_type line_near [set_pkg::DEF_MAX_WIDTH];
   set_pkg::pix_type line_far  [set_pkg::DEF_MAX_WIDTH];
   set_pkg::pix_type win [9];
   int      in_col, in_row, out_col, out_row;

   // Pending input transactions and expected edge flags
   set_pkg::set_req_type raster_q [$];
   set_pkg::set_rsp_type expected_edges [$];

   // Run bookkeeping
   int   items_queued   = 0;
   int   items_accepted = 0;
   int   results_seen   = 0;
   int   edges_seen     = 0;
   int   frames_done    = 0;
   int   error_count    = 0;
   logic sender_rush    = 1'b0;
   logic hold_request   = 1'b0;
   int   send_gap       = 0;
   int   send_burst     = 0;
   int   rsp_wait       = 0;
   int   recv_burst     = 0;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Per-transaction wait: mostly up to MAX_WAIT, with occasional bursts of none
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst_left = int'($urandom_range(10, 60));
         return 0;
      end
      return int'($urandom_range(0, MAX_WAIT));
   endfunction

   function automatic void clear_frame_state();
      win     = '{default: '0};
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Edge predictor: advances the window by one transaction and queues the
   // flag for the delayed position when one is due
   function automatic void predict_edge(input set_pkg::set_req_type item);
      int                   w, h, r, gx, gy, mag2, lim;
      int                   v [9];
      set_pkg::pix_type     cur, far_px, near_px;
      logic                 due;
      set_pkg::set_rsp_type rsp;
      w = clamp_int(int'(cfg_width), set_pkg::MIN_IMAGE_WIDTH, set_pkg::DEF_MAX_WIDTH);
      h = clamp_int(int'(cfg_height), set_pkg::MIN_IMAGE_HEIGHT, set_pkg::DEF_MAX_HEIGHT);
      // flush with no frame open is dropped
      if (item.action == ACT_FLUSH && in_row == 0 && in_col == 0) return;
      // flush inside a frame and anything below the last row read as black
      cur = (item.action == ACT_FLUSH || in_row >= h) ? '0 : item.pixel;
      far_px  = line_far[in_col];
      near_px = line_near[in_col];
      line_far[in_col]  = near_px;
      line_near[in_col] = cur;
      for (r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = far_px;
      win[5] = near_px;
      win[8] = cur;
      due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         in_col = 0;
         if (in_row < int'(set_pkg::ROW_COUNTER_MAX)) in_row++;
      end else begin
         in_col++;
      end
      if (!due) return;
      // zero the neighbors that fall outside the image
      for (r = 0; r < 9; r++) v[r] = int'(win[r]);
      if (out_row == 0) begin
         v[0] = 0; v[1] = 0; v[2] = 0;
      end
      if (out_row + 1 >= h) begin
         v[6] = 0; v[7] = 0; v[8] = 0;
      end
      if (out_col == 0) begin
         v[0] = 0; v[3] = 0; v[6] = 0;
      end
      if (out_col + 1 >= w) begin
         v[2] = 0; v[5] = 0; v[8] = 0;
      end
      gx   = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
      gy   = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
      mag2 = gx * gx + gy * gy;
      lim  = (int'(cfg_thresh) + 1) * (int'(cfg_thresh) + 1);
      rsp.edge_res      = (mag2 >= lim);
      rsp.last_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
      expected_edges.push_back(rsp);
      if (rsp.last_of_frame) begin
         clear_frame_state();
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         if (out_row < int'(set_pkg::ROW_COUNTER_MAX)) out_row++;
      end else begin
         out_col++;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Request driver: offers queued transactions, predicts on acceptance
   always @(posedge clock) begin : drive_req
      logic offer;
      if (reset) begin
         foreach (line_near[i]) begin
            line_near[i] = '0;
            line_far[i]  = '0;
         end
         clear_frame_state();
         cfg_width   = set_pkg::RST_IMAGE_WIDTH;
         cfg_height  = set_pkg::RST_IMAGE_HEIGHT;
         cfg_thresh  = set_pkg::RST_EDGE_THRESHOLD;
         send_gap    = 0;
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            predict_edge(req_payload);
            items_accepted++;
            offer    = 1'b0;
            send_gap = sender_rush ? 0 : draw_wait(send_burst);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (raster_q.size() != 0) begin
               req_payload <= raster_q.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // Result monitor: checks each transaction, paces rsp_ready
   always @(posedge clock) begin : check_rsp
      set_pkg::set_rsp_type want;
      if (reset) begin
         rsp_wait  = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_edges.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing expected (edge %0b last %0b)",
                  results_seen, rsp_payload.edge_res, rsp_payload.last_of_frame));
            end else begin
               want = expected_edges.pop_front();
               if (rsp_payload.edge_res !== want.edge_res)
                  report_mismatch($sformatf("result %0d edge_res %0b, want %0b",
                     results_seen, rsp_payload.edge_res, want.edge_res));
               if (rsp_payload.last_of_frame !== want.last_of_frame)
                  report_mismatch($sformatf("result %0d last_of_frame %0b, want %0b",
                     results_seen, rsp_payload.last_of_frame, want.last_of_frame));
               if (want.edge_res) edges_seen++;
               if (want.last_of_frame) frames_done++;
            end
            rsp_wait = draw_wait(recv_burst);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         // long hold-off requested by the stimulus
         if (hold_request) begin
            rsp_wait     = LONG_HOLD;
            hold_request = 1'b0;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   // Register write; predictor copy follows at the handshake
   task automatic write_reg(input logic [set_pkg::CSR_INDEX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[set_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         set_pkg::CSR_IDX_IMAGE_WIDTH:
            cfg_width  = value[set_pkg::CFG_WIDTH_BITS-1:0];
         set_pkg::CSR_IDX_IMAGE_HEIGHT:
            cfg_height = value[set_pkg::CFG_HEIGHT_BITS-1:0];
         set_pkg::CSR_IDX_EDGE_THRESHOLD:
            cfg_thresh = value[set_pkg::CFG_THRESH_BITS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame_config(input int w_raw, input int h_raw, input int thr_raw);
      write_reg(set_pkg::CSR_IDX_IMAGE_WIDTH, w_raw);
      write_reg(set_pkg::CSR_IDX_IMAGE_HEIGHT, h_raw);
      write_reg(set_pkg::CSR_IDX_EDGE_THRESHOLD, thr_raw);
   endtask

   // Wait for an empty pipeline: nothing queued, offered or outstanding
   task automatic wait_idle();
      while (raster_q.size() != 0 || req_valid || expected_edges.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_item(input logic action, input set_pkg::pix_type pixel);
      set_pkg::set_req_type item;
      item.action = action;
      item.pixel  = pixel;
      raster_q.push_back(item);
      items_queued++;
   endtask

   function automatic set_pkg::pix_type draw_pixel(input img_style_type style);
      case (style)
         STYLE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         STYLE_SMOOTH: return set_pkg::pix_type'(96 + $urandom_range(0, 15));
         default:      return set_pkg::pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Frame body; a flush inside the frame stands for a black pixel, but
   // never on the opening transaction
   task automatic queue_pixels(input int count, input img_style_type style,
                               input bit opens_frame);
      int i;
      for (i = 0; i < count; i++) begin
         if ((i > 0 || !opens_frame) && $urandom_range(0, 24) == 0)
            push_item(ACT_FLUSH, set_pkg::pix_type'($urandom_range(0, 255)));
         else
            push_item(ACT_PIXEL, draw_pixel(style));
      end
   endtask

   // Frame tail: flushes, optionally mixed with pixels below the last row,
   // then a few surplus flushes that the unit drops
   task automatic queue_tail(input int count, input bit mixed);
      int i, n;
      for (i = 0; i < count; i++) begin
         if (mixed && $urandom_range(0, 2) == 0)
            push_item(ACT_PIXEL, set_pkg::pix_type'($urandom_range(0, 255)));
         else
            push_item(ACT_FLUSH, set_pkg::pix_type'($urandom_range(0, 255)));
      end
      n = int'($urandom_range(0, 2));
      for (i = 0; i < n; i++)
         push_item(ACT_FLUSH, set_pkg::pix_type'($urandom_range(0, 255)));
   endtask

   // Stimulus and verdict
   initial begin : stimulus
      int            pass, r, w_raw, h_raw, thr_raw, w_eff, h_eff, random_start;
      img_style_type style;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Vertical step 0/128/255 gives |gx| = 1020 in the center: threshold
      // just below and at the magnitude; early flush on pass 0, late pixels on both
      for (pass = 0; pass < 2; pass++) begin
         wait_idle();
         set_frame_config(3, 3, 1019 + pass);
         for (r = 0; r < 3; r++) begin
            if (pass == 0 && r == 2) push_item(ACT_FLUSH, 8'hFF);
            else push_item(ACT_PIXEL, 8'h00);
            push_item(ACT_PIXEL, 8'd128);
            push_item(ACT_PIXEL, 8'hFF);
         end
         push_item(ACT_FLUSH, 8'h00);
         push_item(ACT_PIXEL, 8'd200);
         push_item(ACT_FLUSH, 8'h00);
         push_item(ACT_PIXEL, 8'h00);
         push_item(ACT_FLUSH, 8'hFF);
      end

      // Receiver holds off while the sender streams: result buffer fills
      wait_idle();
      set_frame_config(16, 8, 100);
      sender_rush  = 1'b1;
      hold_request = 1'b1;
      queue_pixels(128, STYLE_NOISE, 1'b1);
      queue_tail(17, 1'b1);
      while (raster_q.size() != 0) @(negedge clock);
      sender_rush = 1'b0;

      // Sender pauses mid-frame until drained, threshold changes there
      wait_idle();
      set_frame_config(6, 5, 150);
      queue_pixels(12, STYLE_NOISE, 1'b1);
      wait_idle();
      write_reg(set_pkg::CSR_IDX_EDGE_THRESHOLD, 40);
      queue_pixels(18, STYLE_SMOOTH, 1'b0);
      queue_tail(7, 1'b1);

      // Height shrinks below the current row: frame closes at the next row end
      wait_idle();
      set_frame_config(5, 6, 80);
      queue_pixels(20, STYLE_BINARY, 1'b1);
      wait_idle();
      write_reg(set_pkg::CSR_IDX_IMAGE_HEIGHT, 2);
      queue_tail(12, 1'b0);

      // Random frames, mostly small
      random_start = items_queued;
      while (items_queued - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w_raw = int'($urandom_range(0, 1));
            1:       w_raw = int'($urandom_range(9, 40));
            default: w_raw = int'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 19))
            0, 1:    h_raw = 0;
            2:       h_raw = int'($urandom_range(7, 12));
            default: h_raw = int'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 19))
            0:       thr_raw = 0;
            1:       thr_raw = 1442;
            2:       thr_raw = 2047;
            3:       thr_raw = int'($urandom_range(0, 2047));
            default: thr_raw = int'($urandom_range(0, 400));
         endcase
         style = img_style_type'($urandom_range(0, 2));
         w_eff = clamp_int(w_raw, set_pkg::MIN_IMAGE_WIDTH, set_pkg::DEF_MAX_WIDTH);
         h_eff = clamp_int(h_raw, set_pkg::MIN_IMAGE_HEIGHT, set_pkg::DEF_MAX_HEIGHT);
         wait_idle();
         set_frame_config(w_raw, h_raw, thr_raw);
         queue_pixels(w_eff * h_eff, style, 1'b1);
         queue_tail(w_eff + 1, 1'b1);
      end

      wait_idle();
      if (rsp_valid)
         report_mismatch("result transaction left over after the last expected one");
      $display("covered %0d input transactions over %0d frames of up to 40 x 12 pixels,",
         items_accepted, frames_done);
      $display("with clamped sizes, stalls and mid-frame writes: %0d results, %0d edges, %0d mismatches",
         results_seen, edges_seen, error_count);
      if (error_count == 0) begin
         $display("sobel_edge_threshold_unit regression: pass");
      end else begin
         $display("sobel_edge_threshold_unit regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("sobel_edge_threshold_unit regression: fail");
      $finish;
   end

endmodule
